/* hw/rtl/address_range_table_allocator_defines.svh */
// Assertion macros for the address range table allocator.
`ifndef ADDRESS_RANGE_TABLE_ALLOCATOR_DEFINES_SVH
`define ADDRESS_RANGE_TABLE_ALLOCATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ARTA_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ARTA_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

/* hw/rtl/arta_pkg.sv */
// ---------------------------------------------------------------------------
// arta_pkg
// Status codes, modes, flag bit positions and config indices of the range table allocator.
// ---------------------------------------------------------------------------
package arta_pkg;
  localparam logic [1:0] MODE_FIND   = 2'd0;
  localparam logic [1:0] MODE_MAP    = 2'd1;
  localparam logic [1:0] MODE_FREE   = 2'd2;
  localparam logic [1:0] MODE_COMMIT = 2'd3;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NO_GAP     = 4'd1;
  localparam logic [3:0] ST_MISALIGNED = 4'd2;
  localparam logic [3:0] ST_OUT_WINDOW = 4'd3;
  localparam logic [3:0] ST_OVERLAP    = 4'd4;
  localparam logic [3:0] ST_FULL       = 4'd5;
  localparam logic [3:0] ST_NOT_ALLOC  = 4'd6;
  localparam logic [3:0] ST_DOUBLE     = 4'd7;
  localparam logic [3:0] ST_NULL_PAGE  = 4'd8;
  localparam logic [3:0] ST_BAD_FLAGS  = 4'd9;

  localparam int FL_KERNEL    = 0;
  localparam int FL_READONLY  = 1;
  localparam int FL_IMM       = 2;
  localparam int FL_COMMITTED = 3;
  localparam int FL_NULLPAGE  = 4;

  localparam logic CFG_WINDOW_START = 1'b0;
  localparam logic CFG_WINDOW_END   = 1'b1;
endpackage

/* hw/rtl/address_range_table_allocator.sv */
// ---------------------------------------------------------------------------
// address_range_table_allocator
// First-fit allocator over a sorted table of page-aligned reserved ranges.
// ---------------------------------------------------------------------------
// Usage:
//  - Request word (mode, address, size_pages, flags) on in_valid/in_ready.
//  - Result word (result_address, status, page_attributes) on
//    out_valid/out_ready, one per request.
//  - Config writes (cfg_index, cfg_data) set window_start / window_end;
//    write only while idle. A pending config write holds off requests.
// Operation: one request walks the table one entry per cycle. Find and
//  commit walk the ranges in use once; map with an automatic address runs
//  the find walk and then the overlap walk; free and insert also move
//  table entries to close or open a slot. At most MAX_RANGES ranges are in use.
//  in_ready is high only in the idle state; one request at a time.
// Reset: table empty, window [0, 0xFFFFFFFF). No clearing pass.
// Stall: the result is held in the output register until taken; the
//  next request is not accepted until then.
// ---------------------------------------------------------------------------
`include "address_range_table_allocator_defines.svh"
module address_range_table_allocator
  import arta_pkg::*;
#(
  parameter int MAX_RANGES = 16,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic [20:0] size_pages,
  input  logic [4:0]  flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_address,
  output logic [3:0]  status,
  output logic [1:0]  page_attributes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int BW = 32 - PAGE_SHIFT;
  localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_GAP_END, S_MAP_CHK, S_OVL, S_SHIFT_UP, S_INSERT,
    S_FIND_C, S_SHIFT_DN, S_DONE
  } state_t;

  state_t state;
  logic [BW-1:0] mem_base [MAX_RANGES];
  logic [20:0]   mem_len  [MAX_RANGES];
  logic [4:0]    mem_flg  [MAX_RANGES];
  logic [CW-1:0] count, idx, pos;
  logic [31:0]   window_start, window_end;
  logic [1:0]    rmode;
  logic [32:0]   raddr, need, cur;
  logic [20:0]   rpages;
  logic [4:0]    rflags;

  // current entry bounds (33-bit)
  logic [IW-1:0] ix;
  logic [32:0]   lo, hi;
  assign ix = idx[IW-1:0];
  assign lo = {1'b0, mem_base[ix], {PAGE_SHIFT{1'b0}}};
  assign hi = lo + 33'({33'b0, mem_len[ix]} << PAGE_SHIFT);

  // request length in bytes, saturated when it cannot fit in 33 bits
  logic [53:0] need_wide;
  logic [32:0] need_in;
  assign need_wide = {33'b0, size_pages} << PAGE_SHIFT;
  assign need_in = (|need_wide[53:33]) ? '1 : need_wide[32:0];

  logic [33:0] cur_end;
  assign cur_end = {1'b0, cur} + {1'b0, need};
  logic gap_fits;
  assign gap_fits = (cur_end <= {2'b0, window_end});

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // sequencer: one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      window_start <= 32'h0;
      window_end <= 32'hFFFF_FFFF;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_WINDOW_START) window_start <= cfg_data;
            else window_end <= cfg_data;
          end
          if (in_valid && !cfg_valid) begin
            rmode <= mode;
            raddr <= {1'b0, address};
            rpages <= size_pages;
            rflags <= flags;
            need <= need_in;
            cur <= {1'b0, window_start};
            idx <= '0;
            page_attributes <= 2'b0;
            result_address <= 32'h0;
            if (mode == MODE_MAP && ((flags[FL_NULLPAGE] && flags != 5'b10000) ||
                (flags[FL_COMMITTED] && flags[FL_IMM]))) begin
              status <= ST_BAD_FLAGS;
              state <= S_DONE;
              out_valid <= 1'b1;
            end else if (mode == MODE_FIND || (mode == MODE_MAP && address == 32'h0)) begin
              state <= S_SCAN;
            end else if (mode == MODE_MAP) begin
              state <= S_MAP_CHK;
            end else begin
              state <= S_FIND_C;
            end
          end
        end
        // first-fit walk
        S_SCAN: begin
          if (need == 33'h0) begin
            status <= ST_NO_GAP;
            state <= S_DONE;
            out_valid <= 1'b1;
          end else if (idx >= count) begin
            state <= S_GAP_END;
          end else if (lo > cur && (lo - cur) >= need && gap_fits) begin
            raddr <= cur;
            if (rmode == MODE_FIND) begin
              result_address <= cur[31:0];
              status <= ST_OK;
              state <= S_DONE;
              out_valid <= 1'b1;
            end else state <= S_MAP_CHK;
          end else begin
            if (hi > cur) cur <= hi;
            idx <= idx + 1'b1;
          end
        end
        S_GAP_END: begin
          if (gap_fits) begin
            raddr <= cur;
            if (rmode == MODE_FIND) begin
              result_address <= cur[31:0];
              status <= ST_OK;
              state <= S_DONE;
              out_valid <= 1'b1;
            end else state <= S_MAP_CHK;
          end else begin
            status <= ST_NO_GAP;
            state <= S_DONE;
            out_valid <= 1'b1;
          end
        end
        // map checks before the overlap walk
        S_MAP_CHK: begin
          idx <= '0;
          pos <= count;
          cur <= raddr + need;
          if (raddr[PAGE_SHIFT-1:0] != '0) begin
            status <= ST_MISALIGNED;
            state <= S_DONE;
            out_valid <= 1'b1;
          end else if (need == 33'h0 || raddr < {1'b0, window_start} ||
                       {1'b0, raddr} + {1'b0, need} > {2'b0, window_end}) begin
            status <= ST_OUT_WINDOW;
            state <= S_DONE;
            out_valid <= 1'b1;
          end else if (count >= MAXC) begin
            status <= ST_FULL;
            state <= S_DONE;
            out_valid <= 1'b1;
          end else state <= S_OVL;
        end
        S_OVL: begin
          if (idx >= count) begin
            idx <= count;
            state <= S_SHIFT_UP;
          end else if (raddr < hi && lo < cur) begin
            status <= ST_OVERLAP;
            state <= S_DONE;
            out_valid <= 1'b1;
          end else begin
            if (pos == count && lo > raddr) pos <= idx;
            idx <= idx + 1'b1;
          end
        end
        // open a slot at pos
        S_SHIFT_UP: begin
          if (idx > pos) begin
            mem_base[ix] <= mem_base[IW'(idx - 1'b1)];
            mem_len[ix]  <= mem_len[IW'(idx - 1'b1)];
            mem_flg[ix]  <= mem_flg[IW'(idx - 1'b1)];
            idx <= idx - 1'b1;
          end else state <= S_INSERT;
        end
        S_INSERT: begin
          mem_base[IW'(pos)] <= raddr[31:PAGE_SHIFT];
          mem_len[IW'(pos)]  <= rpages;
          mem_flg[IW'(pos)]  <= rflags;
          count <= count + 1'b1;
          result_address <= raddr[31:0];
          status <= ST_OK;
          state <= S_DONE;
          out_valid <= 1'b1;
        end
        // containing-range walk for free and commit
        S_FIND_C: begin
          if (idx >= count) begin
            status <= ST_NOT_ALLOC;
            state <= S_DONE;
            out_valid <= 1'b1;
          end else if (raddr >= lo && raddr < hi) begin
            if (rmode == MODE_FREE) begin
              result_address <= lo[31:0];
              status <= ST_OK;
              state <= S_SHIFT_DN;
            end else begin
              state <= S_DONE;
              out_valid <= 1'b1;
              if (mem_flg[ix][FL_IMM] || mem_flg[ix][FL_COMMITTED]) status <= ST_DOUBLE;
              else if (mem_flg[ix][FL_NULLPAGE]) status <= ST_NULL_PAGE;
              else begin
                status <= ST_OK;
                result_address <= {raddr[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                page_attributes <= {~mem_flg[ix][FL_READONLY], mem_flg[ix][FL_KERNEL]};
              end
            end
          end else idx <= idx + 1'b1;
        end
        // close the gap left by a freed entry
        S_SHIFT_DN: begin
          if (idx + 1'b1 < count) begin
            mem_base[ix] <= mem_base[IW'(idx + 1'b1)];
            mem_len[ix]  <= mem_len[IW'(idx + 1'b1)];
            mem_flg[ix]  <= mem_flg[IW'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end else begin
            count <= count - 1'b1;
            state <= S_DONE;
            out_valid <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ARTA_ASSERT_IMP(a_count_max, 1'b1, count <= MAXC, "range count beyond table depth")
  `ARTA_ASSERT_IMP(a_valid_done, out_valid, state == S_DONE, "result shown outside done state")
  `ARTA_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "second request taken while busy")
endmodule
